### rtl/core/crcns_pkg.sv
// Package with the types, constants and CRC function of the checked-record scanner.
`default_nettype none

package crcns_pkg;

    localparam int unsigned HDR_BYTES     = 24;
    localparam int unsigned CRC_FIELD_POS = 20;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [23:0] MAX_PAYLOAD_RESET = 24'd65536;

    // Magic tag, first byte of the file in the low byte.
    localparam logic [63:0] MAGIC_TAG = 64'h3130_304C_4143_5244;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register index, taken from the word part of the byte address.
    typedef enum logic [0:0] {
        REG_MAX_PAYLOAD = 1'b0,
        REG_UNUSED      = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] generation;
        logic [31:0] length;
    } rec_result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/crc_record_check_newest_slot.sv
// Top level of the checked-record scanner with newest-slot selection.
// The block takes one byte of a stored record per item and sustains one item every clock cycle
// while no last byte is stalled; the limit is the byte-wide CRC-32 update between the input
// register and the result register. An accepted byte is held in the input register and is
// processed there; on a last byte the verdict and the best record so far are written to the
// output register as the byte leaves the input register, which raises out_valid. Non-last
// bytes give no result. A result waiting in the output register stalls only a following last byte.
`default_nettype none

module crc_record_check_newest_slot (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [crcns_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [crcns_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [crcns_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                  pready,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [7:0]                       data_byte,
    input  wire logic                             last_byte,
    input  wire logic                             scan_start,
    input  wire logic                             slot_index,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  record_ok,
    output logic [63:0]                           record_generation,
    output logic [31:0]                           payload_length,
    output logic                                  best_found,
    output logic                                  best_slot,
    output logic [63:0]                           best_generation
);
    import crcns_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_scan_reg;
    logic        s1_slot_reg;
    logic        out_valid_reg, out_valid_next;
    logic        s1_step;
    logic        in_fire;
    logic [23:0] max_payload;
    rec_result_t rec;

    crcns_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_payload (max_payload)
    );

    // A byte in the input register moves on unless it is a last byte and the
    // output register still holds an item that has not been taken.
    assign s1_step  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_step;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = in_fire ? 1'b1 : (s1_valid_reg && !s1_step);
        out_valid_next = out_valid_reg && !out_ready;
        if (s1_step && s1_last_reg) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
            s1_scan_reg <= scan_start;
            s1_slot_reg <= slot_index;
        end
    end

    crcns_rec u_rec (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_step),
        .data_byte   (s1_byte_reg),
        .last_byte   (s1_last_reg),
        .scan_start  (s1_scan_reg),
        .max_payload (max_payload),
        .result      (rec)
    );

    crcns_best u_best (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (s1_step),
        .last_byte         (s1_last_reg),
        .scan_start        (s1_scan_reg),
        .slot_index        (s1_slot_reg),
        .rec               (rec),
        .record_ok         (record_ok),
        .record_generation (record_generation),
        .payload_length    (payload_length),
        .best_found        (best_found),
        .best_slot         (best_slot),
        .best_generation   (best_generation)
    );

    assign out_valid = out_valid_reg;

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("last byte advanced over a result that was not taken");

    a_ok_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && record_ok) |-> best_found)
        else $error("valid record reported with no best record");

    a_none_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !best_found) |-> (best_slot && (best_generation == '0)))
        else $error("best record not at its empty value while none found");

    a_best_newest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && record_ok) |-> (best_generation >= record_generation))
        else $error("best generation older than a valid record");

endmodule

`default_nettype wire

### rtl/core/crcns_regs.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module crcns_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [crcns_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [crcns_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [crcns_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                  pready,
    output logic      [23:0]                      max_payload
);
    import crcns_pkg::*;

    logic [23:0] max_payload_reg;
    logic [23:0] max_payload_next;
    reg_index_t  index;

    assign index = reg_index_t'(paddr[CFG_ADDR_W-1]);

    always_comb
    begin
        max_payload_next = max_payload_reg;
        if (psel && penable && pwrite && (index == REG_MAX_PAYLOAD)) begin
            max_payload_next = pwdata[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else begin
            max_payload_reg <= max_payload_next;
        end
    end

    always_comb
    begin
        unique case (index)
            REG_MAX_PAYLOAD: prdata = {8'd0, max_payload_reg};
            default:         prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign max_payload = max_payload_reg;

endmodule

`default_nettype wire

### rtl/core/crcns_rec.sv
// Per-record header capture, running CRC and framing verdict.
`default_nettype none

module crcns_rec (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   last_byte,
    input  wire logic                   scan_start,
    input  wire logic [23:0]            max_payload,
    output crcns_pkg::rec_result_t      result
);
    import crcns_pkg::*;

    logic [31:0] crc_reg,   crc_next;
    logic [31:0] count_reg, count_next;
    logic        magic_reg, magic_next;
    logic [63:0] gen_reg,   gen_next;
    logic [31:0] len_reg,   len_next;
    logic [31:0] hcrc_reg,  hcrc_next;

    logic [31:0] crc_base, count_base, len_base, hcrc_base;
    logic [63:0] gen_base;
    logic        magic_base;
    logic        in_magic, in_gen, in_len, in_crc;
    logic [7:0]  tag_byte;

    // A scan start restarts the record before this byte is taken.
    always_comb
    begin
        if (scan_start) begin
            crc_base   = CRC_INIT;
            count_base = '0;
            magic_base = 1'b1;
            gen_base   = '0;
            len_base   = '0;
            hcrc_base  = '0;
        end else begin
            crc_base   = crc_reg;
            count_base = count_reg;
            magic_base = magic_reg;
            gen_base   = gen_reg;
            len_base   = len_reg;
            hcrc_base  = hcrc_reg;
        end
    end

    assign in_magic = (count_base[31:3] == '0);
    assign in_gen   = (count_base[31:4] == '0) && count_base[3];
    assign in_len   = (count_base[31:5] == '0) && (count_base[4:2] == 3'b100);
    assign in_crc   = (count_base[31:5] == '0) && (count_base[4:2] == 3'b101);
    assign tag_byte = MAGIC_TAG[8*count_base[2:0] +: 8];

    always_comb
    begin
        magic_next = magic_base && (!in_magic || (data_byte == tag_byte));
        gen_next   = gen_base;
        len_next   = len_base;
        hcrc_next  = hcrc_base;
        for (int i = 0; i < 8; i++) begin
            if (in_gen && (count_base[2:0] == 3'(i))) begin
                gen_next[8*i +: 8] = data_byte;
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (in_len && (count_base[1:0] == 2'(i))) begin
                len_next[8*i +: 8] = data_byte;
            end
            if (in_crc && (count_base[1:0] == 2'(i))) begin
                hcrc_next[8*i +: 8] = data_byte;
            end
        end
        crc_next   = in_crc ? crc_base : crc_byte(crc_base, data_byte);
        count_next = (count_base == '1) ? count_base : count_base + 32'd1;
    end

    always_comb
    begin
        result.ok = (count_next > 32'(HDR_BYTES))
                 && ({8'd0, max_payload} >= len_next)
                 && magic_next
                 && (gen_next != '0)
                 && (({1'b0, len_next} + 33'(HDR_BYTES)) == {1'b0, count_next})
                 && (hcrc_next == ~crc_next);
        result.generation = gen_next;
        result.length     = len_next;
    end

    // After a last byte the record state returns to its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
            magic_reg <= 1'b1;
            gen_reg   <= '0;
            len_reg   <= '0;
            hcrc_reg  <= '0;
        end else if (step) begin
            if (last_byte) begin
                crc_reg   <= CRC_INIT;
                count_reg <= '0;
                magic_reg <= 1'b1;
                gen_reg   <= '0;
                len_reg   <= '0;
                hcrc_reg  <= '0;
            end else begin
                crc_reg   <= crc_next;
                count_reg <= count_next;
                magic_reg <= magic_next;
                gen_reg   <= gen_next;
                len_reg   <= len_next;
                hcrc_reg  <= hcrc_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/crcns_best.sv
// Newest valid record tracking across a scan, and the result register.
`default_nettype none

module crcns_best (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic                   last_byte,
    input  wire logic                   scan_start,
    input  wire logic                   slot_index,
    input  wire crcns_pkg::rec_result_t rec,
    output logic                        record_ok,
    output logic [63:0]                 record_generation,
    output logic [31:0]                 payload_length,
    output logic                        best_found,
    output logic                        best_slot,
    output logic [63:0]                 best_generation
);
    import crcns_pkg::*;

    logic [63:0] newest_gen_reg,  newest_gen_next,  newest_gen_base;
    logic        newest_slot_reg, newest_slot_next, newest_slot_base;
    logic        any_valid_reg,   any_valid_next,   any_valid_base;

    always_comb
    begin
        if (scan_start) begin
            newest_gen_base  = '0;
            newest_slot_base = 1'b1;
            any_valid_base   = 1'b0;
        end else begin
            newest_gen_base  = newest_gen_reg;
            newest_slot_base = newest_slot_reg;
            any_valid_base   = any_valid_reg;
        end
        newest_gen_next  = newest_gen_base;
        newest_slot_next = newest_slot_base;
        any_valid_next   = any_valid_base;
        // Only a strictly newer generation replaces the best record.
        if (last_byte && rec.ok && (rec.generation > newest_gen_base)) begin
            newest_gen_next  = rec.generation;
            newest_slot_next = slot_index;
            any_valid_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            newest_gen_reg  <= '0;
            newest_slot_reg <= 1'b1;
            any_valid_reg   <= 1'b0;
        end else if (step) begin
            newest_gen_reg  <= newest_gen_next;
            newest_slot_reg <= newest_slot_next;
            any_valid_reg   <= any_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && last_byte) begin
            record_ok         <= rec.ok;
            record_generation <= rec.generation;
            payload_length    <= rec.length;
            best_found        <= any_valid_next;
            best_slot         <= newest_slot_next;
            best_generation   <= newest_gen_next;
        end
    end

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking bench for the checked-record scanner: record verdicts and newest-slot tracking.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import crcns_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [63:0] gen;
        logic [31:0] len;
        logic        found;
        logic        slot;
        logic [63:0] best_gen;
    } verdict_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       scan;
        logic       slot;
        logic       typed;
        verdict_t   want;
    } dir_row_t;

    typedef enum int {
        KIND_GOOD,
        KIND_BAD_TAG,
        KIND_ZERO_GEN,
        KIND_LEN_OFF,
        KIND_BAD_CRC,
        KIND_OVER_LIMIT,
        KIND_SHORT,
        KIND_NOISE
    } rec_kind_t;

    localparam verdict_t NONE_YET = '{1'b0, 64'd0, 32'd0, 1'b0, 1'b1, 64'd0};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            data_byte;
    logic                  last_byte;
    logic                  scan_start;
    logic                  slot_index;
    logic                  out_valid;
    logic                  out_ready;
    logic                  record_ok;
    logic [63:0]           record_generation;
    logic [31:0]           payload_length;
    logic                  best_found;
    logic                  best_slot;
    logic [63:0]           best_generation;

    crc_record_check_newest_slot dut (.*);

    // Predictor state: current record and best record of the scan.
    logic [23:0] limit_now;
    logic [31:0] run_crc;
    logic [31:0] run_count;
    logic        tag_ok;
    logic [63:0] hdr_gen;
    logic [31:0] hdr_len;
    logic [31:0] hdr_crc;
    logic [63:0] top_gen;
    logic        top_slot;
    logic        top_found;

    verdict_t verdicts[$];

    int  bytes_sent;
    int  records_done;
    int  good_records;
    int  mismatches;
    bit  gaps_allowed;
    bit  sender_gaps;
    bit  squeezed;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void record_clear();
        run_crc   = CRC_INIT;
        run_count = '0;
        tag_ok    = 1'b1;
        hdr_gen   = '0;
        hdr_len   = '0;
        hdr_crc   = '0;
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic l, input logic s, input logic slot,
                             output bit produced, output verdict_t v);
        int unsigned p;
        logic        good;
        produced = 1'b0;
        v = '0;
        if (s)
        begin
            top_gen   = '0;
            top_slot  = 1'b1;
            top_found = 1'b0;
            record_clear();
        end
        p = run_count;
        if (p < 8)
        begin
            if (b != MAGIC_TAG[8*p +: 8])
                tag_ok = 1'b0;
        end
        else if (p < 16)
            hdr_gen[8*(p-8) +: 8] = b;
        else if (p < CRC_FIELD_POS)
            hdr_len[8*(p-16) +: 8] = b;
        else if (p < HDR_BYTES)
            hdr_crc[8*(p-CRC_FIELD_POS) +: 8] = b;
        // The CRC field itself is left out of the checksum.
        if (p < CRC_FIELD_POS || p >= HDR_BYTES)
            run_crc = crc_step(run_crc, b);
        if (run_count != '1)
            run_count++;
        if (l)
        begin
            good = (run_count > HDR_BYTES) && (hdr_len <= {8'd0, limit_now}) && tag_ok
                   && (hdr_gen != 64'd0)
                   && (({32'd0, hdr_len} + HDR_BYTES) == {32'd0, run_count})
                   && (hdr_crc == ~run_crc);
            // Only a strictly newer generation takes over the best record.
            if (good && hdr_gen > top_gen)
            begin
                top_gen   = hdr_gen;
                top_slot  = slot;
                top_found = 1'b1;
            end
            v = '{good, hdr_gen, hdr_len, top_found, top_slot, top_gen};
            produced = 1'b1;
            record_clear();
        end
    endtask

    task automatic offer_byte(input logic [7:0] b, input logic l, input logic s, input logic slot,
                              input logic typed, input verdict_t want);
        bit       produced;
        verdict_t v;
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        last_byte  <= l;
        scan_start <= s;
        slot_index <= slot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        scan_byte(b, l, s, slot, produced, v);
        if (produced)
        begin
            verdicts.push_back(typed ? want : v);
            records_done++;
            if (v.ok)
                good_records++;
        end
    endtask

    task automatic write_limit(input logic [23:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_PAYLOAD, 2'b00};
        // The upper bits of the bus word are not part of the register.
        pwdata  <= {8'($urandom_range(0, 255)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_now = value;
    endtask

    task automatic send_record();
        logic [7:0]  rec[$];
        logic [63:0] gen;
        logic [31:0] plen;
        logic [31:0] lfield;
        logic [31:0] crc;
        rec_kind_t   kind;
        int unsigned pick;
        int unsigned room;
        int unsigned cut;
        logic        slot;
        logic        fresh;
        pick  = $urandom_range(0, 18);
        kind  = (pick < 12) ? KIND_GOOD : rec_kind_t'(pick - 11);
        slot  = 1'($urandom_range(0, 1));
        fresh = ($urandom_range(0, 3) == 0);
        sender_gaps = gaps_allowed && ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 7))
            0: gen = 64'd1;
            1: gen = '1;
            2: gen = top_gen;
            3: gen = top_gen - 64'd1;
            4: gen = top_gen + 64'd1;
            default: gen = {$urandom, $urandom};
        endcase
        if (kind == KIND_ZERO_GEN)
            gen = '0;
        room = (limit_now == 0) ? 1 : ((limit_now < 16) ? limit_now : 16);
        plen = $urandom_range(1, room);
        if ($urandom_range(0, 15) == 0)
            plen = $urandom_range(1, (limit_now > 0 && limit_now < 80) ? limit_now : 80);
        if (kind == KIND_OVER_LIMIT && limit_now < 80)
            plen = limit_now + 1;
        lfield = plen;
        if (kind == KIND_OVER_LIMIT && limit_now >= 80)
            lfield = {8'd0, limit_now} + 32'd1;
        if (kind == KIND_LEN_OFF)
        begin
            case ($urandom_range(0, 2))
                0: lfield = plen + 32'd1;
                1: lfield = plen - 32'd1;
                default: lfield = $urandom;
            endcase
        end
        for (int i = 0; i < 8; i++)
            rec.push_back(MAGIC_TAG[8*i +: 8]);
        for (int i = 0; i < 8; i++)
            rec.push_back(gen[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            rec.push_back(lfield[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            rec.push_back(8'h00);
        for (int i = 0; i < plen; i++)
            rec.push_back(8'($urandom_range(0, 255)));
        if (kind == KIND_BAD_TAG)
        begin
            cut = $urandom_range(0, 7);
            rec[cut] = rec[cut] ^ 8'($urandom_range(1, 255));
        end
        crc = CRC_INIT;
        foreach (rec[i])
            if (i < CRC_FIELD_POS || i >= HDR_BYTES)
                crc = crc_step(crc, rec[i]);
        crc = ~crc;
        if (kind == KIND_BAD_CRC)
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++)
            rec[CRC_FIELD_POS + i] = crc[8*i +: 8];
        if (kind == KIND_SHORT)
        begin
            cut = $urandom_range(1, HDR_BYTES);
            while (rec.size() > cut)
                void'(rec.pop_back());
        end
        if (kind == KIND_NOISE)
        begin
            rec.delete();
            repeat ($urandom_range(1, 40))
                rec.push_back(8'($urandom_range(0, 255)));
        end
        // Noise may also restart the scan in the middle of a record.
        foreach (rec[i])
            offer_byte(rec[i], i == rec.size() - 1,
                       (i == 0 && fresh) || (kind == KIND_NOISE && $urandom_range(0, 15) == 0),
                       slot, 1'b0, '0);
    endtask

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    initial
    begin
        verdict_t w;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            // One long hold-off so that a waiting result blocks the next last byte.
            if (!squeezed && bytes_sent >= 600)
            begin
                squeezed = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (gaps_allowed && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (verdicts.size() == 0)
                begin
                    $display("%0t: result with nothing expected, record_ok %0b gen 0x%0h",
                             $time, record_ok, record_generation);
                    mismatches++;
                end
                else
                begin
                    w = verdicts.pop_front();
                    compare_field("record_ok", w.ok, record_ok);
                    compare_field("record_generation", w.gen, record_generation);
                    compare_field("payload_length", w.len, payload_length);
                    compare_field("best_found", w.found, best_found);
                    compare_field("best_slot", w.slot, best_slot);
                    compare_field("best_generation", w.best_gen, best_generation);
                end
            end
        end
    end

    initial
    begin
        dir_row_t    plan[$];
        logic [23:0] phase_limit[6];
        int          budget[6];
        int          stop_at;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        in_valid   <= 1'b0;
        data_byte  <= '0;
        last_byte  <= 1'b0;
        scan_start <= 1'b0;
        slot_index <= 1'b0;
        gaps_allowed = 1'b1;
        sender_gaps  = 1'b1;
        limit_now    = MAX_PAYLOAD_RESET;
        top_gen      = '0;
        top_slot     = 1'b1;
        top_found    = 1'b0;
        record_clear();
        phase_limit[0] = MAX_PAYLOAD_RESET;
        phase_limit[1] = 24'd1;
        phase_limit[2] = 24'hFF_FFFF;
        phase_limit[3] = 24'd0;
        phase_limit[4] = 24'($urandom_range(2, 40));
        phase_limit[5] = MAX_PAYLOAD_RESET;
        budget = '{250, 250, 250, 150, 250, 400};

        // A lone byte holds no header field at all.
        plan.push_back(dir_row_t'{8'h00, 1'b1, 1'b1, 1'b0, 1'b1, NONE_YET});
        plan.push_back(dir_row_t'{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, NONE_YET});
        // Full tag and an all-ones generation, cut off after the first length byte.
        plan.push_back(dir_row_t'{MAGIC_TAG[7:0],   1'b0, 1'b1, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{MAGIC_TAG[15:8],  1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{MAGIC_TAG[23:16], 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{MAGIC_TAG[31:24], 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{MAGIC_TAG[39:32], 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{MAGIC_TAG[47:40], 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{MAGIC_TAG[55:48], 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{MAGIC_TAG[63:56], 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back(dir_row_t'{8'h05, 1'b1, 1'b0, 1'b1, 1'b1,
                                  verdict_t'{1'b0, '1, 32'd5, 1'b0, 1'b1, 64'd0}});
        // New scan on a three-byte record that carries no generation.
        plan.push_back(dir_row_t'{8'h80, 1'b0, 1'b1, 1'b0, 1'b0, '0});
        plan.push_back(dir_row_t'{8'h7F, 1'b0, 1'b0, 1'b0, 1'b0, '0});
        plan.push_back(dir_row_t'{8'h00, 1'b1, 1'b0, 1'b0, 1'b1, NONE_YET});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            offer_byte(plan[i].data, plan[i].last, plan[i].scan, plan[i].slot,
                       plan[i].typed, plan[i].want);

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
            begin
                in_valid <= 1'b0;
                while (verdicts.size() != 0)
                    @(posedge clk);
                repeat (4) @(posedge clk);
                write_limit(phase_limit[ph]);
            end
            if (ph == 5)
                gaps_allowed = 1'b0;
            stop_at = bytes_sent + budget[ph];
            while (bytes_sent < stop_at)
                send_record();
        end

        in_valid <= 1'b0;
        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("summary: %0d bytes in %0d records, %0d valid, limits 0, 1, max, %0d and reset",
                 bytes_sent, records_done, good_records, phase_limit[4]);
        $display("summary: %0d field mismatches", mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
